@@ hw/rtl/wfss_pkg.sv @@
`timescale 1ns / 1ps
package wfss_pkg;

    localparam int TIME_W   = 48;
    localparam int IW_MAX_W = 25;

    localparam logic [2:0] MODE_SET_PRIO = 3'd0;
    localparam logic [2:0] MODE_ACTIVATE = 3'd1;
    localparam logic [2:0] MODE_PICK     = 3'd2;
    localparam logic [2:0] MODE_REPORT   = 3'd3;
    localparam logic [2:0] MODE_DEACT    = 3'd4;

    localparam logic [1:0] ST_GRANTED = 2'd0;
    localparam logic [1:0] ST_NODATA  = 2'd1;
    localparam logic [1:0] ST_ACK     = 2'd2;

    localparam logic [15:0] CAP_RESET = 16'd1200;

    // per-stream write request
    typedef struct packed {
        logic                  we_iw;
        logic                  we_vt;
        logic                  we_ft;
        logic [IW_MAX_W-1:0]   iw;
        logic [TIME_W-1:0]     vt;
        logic [TIME_W-1:0]     ft;
    } cell_wr_t;

    // running minimum passed along the chain
    typedef struct packed {
        logic              any;
        logic [TIME_W-1:0] ft;
    } cand_t;

endpackage

@@ hw/rtl/wfss_cell.sv @@
`timescale 1ns / 1ps
module wfss_cell #(
    parameter int POS  = 0,
    parameter int IDXW = 4,
    parameter int IWW  = 17
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [IDXW-1:0]             wr_idx,
    input  wfss_pkg::cell_wr_t          wr,
    input  wfss_pkg::cand_t             cand_in,
    input  logic [IDXW-1:0]             idx_in,
    output wfss_pkg::cand_t             cand_out,
    output logic [IDXW-1:0]             idx_out,
    output logic [IWW-1:0]              iw,
    output logic [wfss_pkg::TIME_W-1:0] vt,
    output logic [wfss_pkg::TIME_W-1:0] ft
);
    import wfss_pkg::*;

    logic [IWW-1:0]    iw_reg;
    logic [TIME_W-1:0] vt_reg;
    logic [TIME_W-1:0] ft_reg;
    cand_t             cand_reg;
    logic [IDXW-1:0]   idx_reg;
    logic              hit;
    logic              take;

    assign hit  = (wr_idx == IDXW'(POS));
    assign take = (ft_reg != '0) && (!cand_in.any || ft_reg < cand_in.ft);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iw_reg <= IWW'(1) << (IWW - 1);
            vt_reg <= '0;
            ft_reg <= '0;
        end else if (hit) begin
            if (wr.we_iw) iw_reg <= wr.iw[IWW-1:0];
            if (wr.we_vt) vt_reg <= wr.vt;
            if (wr.we_ft) ft_reg <= wr.ft;
        end
    end

    // strict less keeps the lower index on a tie
    always_ff @(posedge aclk) begin
        if (take) begin
            cand_reg.any <= 1'b1;
            cand_reg.ft  <= ft_reg;
            idx_reg      <= IDXW'(POS);
        end else begin
            cand_reg <= cand_in;
            idx_reg  <= idx_in;
        end
    end

    assign cand_out = cand_reg;
    assign idx_out  = idx_reg;
    assign iw       = iw_reg;
    assign vt       = vt_reg;
    assign ft       = ft_reg;

endmodule

@@ hw/rtl/wfss_div.sv @@
`timescale 1ns / 1ps
module wfss_div #(
    parameter int FRAC = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [15:0]     divisor,
    output logic            done,
    output logic [FRAC:0]   quotient
);
    localparam int CW = $clog2(FRAC + 2);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [16:0]   rem_reg;
    logic [16:0]   den_reg;
    logic [FRAC:0] q_reg;
    logic          done_reg;
    logic [16:0]   rem_sh;
    logic          ge;

    // numerator is 2^FRAC: only the first bit shifted in is one
    assign rem_sh = {rem_reg[15:0], (cnt_reg == '0)};
    assign ge     = (rem_sh >= den_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(FRAC)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= {1'b0, divisor};
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? (rem_sh - den_reg) : rem_sh;
            q_reg   <= {q_reg[FRAC-1:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ hw/rtl/weighted_fair_stream_scheduler.sv @@
`timescale 1ns / 1ps
// Pick: the running minimum ripples one cell per cycle along the cells;
//   set priority yields one quotient bit per cycle; report runs multiply
//   and add, again for a re-arm (done at once if nothing was produced);
//   activate runs multiply and add; deactivate and other modes go to done.
// Throughput: one request at a time; the next is taken once its result sits
//   in the output register.
// Reset: synchronous, active-low aresetn; weights to one, times to zero.
module weighted_fair_stream_scheduler #(
    parameter int NUM_STREAMS    = 16,
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] stream_index, [19:4] priority_req, [20] produced,
    // [36:21] payload_bytes, [52:37] next_bytes, [55:53] zero
    input  logic [55:0] s_tdata,
    // [2:0] mode
    input  logic [2:0]  s_tuser,
    // chunk_is_end
    input  logic        s_tlast,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] granted_stream, [51:4] global_virtual_time, [55:52] zero
    output logic [55:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wfss_pkg::*;

    localparam int IDXW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int IWW  = TIME_FRAC_BITS + 1;
    localparam int PW   = 16 + IWW;
    localparam logic [PW-1:0] ONE_T = PW'(1) << TIME_FRAC_BITS;

    // one-hot sequencer
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_SCAN = 6'b000100,
        S_MUL  = 6'b001000,
        S_ADD  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t            state_reg;
    logic              ie_reg;
    logic [15:0]       cap_reg;
    logic [TIME_W-1:0] sched_reg;
    logic [IDXW-1:0]   cur_reg;
    logic              lme_reg;
    logic              latch_reg;

    logic [IDXW-1:0]   op_idx_reg;
    logic [TIME_W-1:0] op_base_reg;
    logic [15:0]       op_bytes_reg;
    logic [PW-1:0]     prod_reg;
    logic              act_reg;      // activation pass: writes the finish time
    logic              rep_end_reg;
    logic [15:0]       rep_next_reg;
    logic [IDXW-1:0]   cnt_reg;
    logic [1:0]        status_reg;
    logic [3:0]        grant_reg;

    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [3:0]        out_grant_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic              out_load;

    // request fields
    logic [2:0]  in_mode;
    logic [3:0]  in_idx;
    logic [15:0] in_prio;
    logic        in_prod;
    logic [15:0] in_pay;
    logic [15:0] in_next;
    logic        accept;
    logic        idx_ok;

    assign in_mode = s_tuser;
    assign in_idx  = s_tdata[3:0];
    assign in_prio = s_tdata[19:4];
    assign in_prod = s_tdata[20];
    assign in_pay  = s_tdata[36:21];
    assign in_next = s_tdata[52:37];
    assign idx_ok  = (int'(in_idx) < NUM_STREAMS);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // result register loads when the finished request can move in
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    // configuration
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {16'd0, cap_reg} : {31'd0, ie_reg};

    // cell row
    cell_wr_t          wr;
    logic [IDXW-1:0]   wr_idx;
    cand_t             cand_c [NUM_STREAMS+1];
    logic [IDXW-1:0]   idx_c  [NUM_STREAMS+1];
    logic [IWW-1:0]    iw_a   [NUM_STREAMS];
    logic [TIME_W-1:0] vt_a   [NUM_STREAMS];
    logic [TIME_W-1:0] ft_a   [NUM_STREAMS];

    assign cand_c[0] = '0;
    assign idx_c[0]  = '0;

    for (genvar g = 0; g < NUM_STREAMS; g++) begin : g_cell
        wfss_cell #(.POS(g), .IDXW(IDXW), .IWW(IWW)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_idx   (wr_idx),
            .wr       (wr),
            .cand_in  (cand_c[g]),
            .idx_in   (idx_c[g]),
            .cand_out (cand_c[g+1]),
            .idx_out  (idx_c[g+1]),
            .iw       (iw_a[g]),
            .vt       (vt_a[g]),
            .ft       (ft_a[g])
        );
    end

    // read port: request index while idle, latched index afterwards
    logic [IDXW-1:0]   rd_idx;
    logic [IWW-1:0]    iw_rd;
    logic [TIME_W-1:0] vt_rd;
    logic [TIME_W-1:0] ft_rd;
    assign rd_idx = (state_reg == S_IDLE) ? IDXW'(in_idx) : op_idx_reg;
    assign iw_rd  = iw_a[rd_idx];
    assign vt_rd  = vt_a[rd_idx];
    assign ft_rd  = ft_a[rd_idx];

    // priority divider: floor(2^F / priority), zero priority taken as one
    logic          div_start;
    logic          div_done;
    logic [IWW-1:0] div_q;
    wfss_div #(.FRAC(TIME_FRAC_BITS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  ((in_prio == 16'd0) ? 16'd1 : in_prio),
        .done     (div_done),
        .quotient (div_q)
    );

    // saturating finish add
    logic [TIME_W:0]   sum_w;
    logic [TIME_W-1:0] sum_sat;
    assign sum_w   = {1'b0, op_base_reg} + (TIME_W+1)'(prod_reg);
    assign sum_sat = sum_w[TIME_W] ? '1 : sum_w[TIME_W-1:0];

    // activation byte count, capped, zero cap acts as one byte
    logic [15:0] cap1;
    logic [15:0] act_bytes_in;
    logic [15:0] act_bytes_rep;
    assign cap1          = (cap_reg == 16'd0) ? 16'd1 : cap_reg;
    assign act_bytes_in  = (in_next < cap1) ? in_next : cap1;
    assign act_bytes_rep = (rep_next_reg < cap1) ? rep_next_reg : cap1;

    logic scan_end;
    logic resched;
    assign scan_end = (cnt_reg == IDXW'(NUM_STREAMS - 1));
    assign resched  = ie_reg || lme_reg;

    // write port
    always_comb begin
        wr        = '0;
        wr_idx    = op_idx_reg;
        div_start = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                wr_idx = IDXW'(in_idx);
                if (accept && in_mode == MODE_DEACT && idx_ok) begin
                    wr.we_ft = 1'b1;
                end
                if (accept && in_mode == MODE_SET_PRIO && idx_ok) begin
                    div_start = 1'b1;
                end
            end
            S_DIV: begin
                wr.we_iw = div_done;
                wr.iw    = IW_MAX_W'(div_q);
            end
            S_SCAN: begin
                wr_idx   = idx_c[NUM_STREAMS];
                wr.we_ft = scan_end && cand_c[NUM_STREAMS].any && resched;
            end
            S_ADD: begin
                wr.we_vt = 1'b1;
                if (act_reg) begin
                    wr.vt    = op_base_reg;
                    wr.we_ft = 1'b1;
                    wr.ft    = sum_sat;
                end else begin
                    wr.vt    = sum_sat;
                    wr.we_ft = !latch_reg && (rep_next_reg == 16'd0);
                end
            end
            S_MUL, S_DONE: begin
                wr = '0;
            end
            default: begin
                wr = '0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ie_reg        <= 1'b0;
            cap_reg       <= CAP_RESET;
            sched_reg     <= '0;
            cur_reg       <= '0;
            lme_reg       <= 1'b1;
            latch_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2]) cap_reg <= pwdata[15:0];
                else          ie_reg  <= pwdata[0];
            end
            if (out_load)      out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        status_reg <= ST_ACK;
                        grant_reg  <= 4'd0;
                        op_idx_reg <= IDXW'(in_idx);
                        state_reg  <= S_DONE;
                        case (in_mode)
                            MODE_SET_PRIO: begin
                                if (idx_ok) state_reg <= S_DIV;
                            end
                            MODE_ACTIVATE: begin
                                if (idx_ok && ft_rd == '0 && in_next != 16'd0) begin
                                    op_base_reg  <= sched_reg;
                                    op_bytes_reg <= act_bytes_in;
                                    act_reg      <= 1'b1;
                                    state_reg    <= S_MUL;
                                end
                            end
                            MODE_PICK: begin
                                cnt_reg   <= '0;
                                state_reg <= S_SCAN;
                            end
                            MODE_REPORT: begin
                                if (in_prod) begin
                                    op_idx_reg   <= cur_reg;
                                    op_bytes_reg <= in_pay;
                                    rep_end_reg  <= s_tlast;
                                    rep_next_reg <= in_next;
                                    act_reg      <= 1'b0;
                                    state_reg    <= S_MUL;
                                end
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) state_reg <= S_DONE;
                end
                S_SCAN: begin
                    cnt_reg <= cnt_reg + IDXW'(1);
                    if (scan_end) begin
                        state_reg <= S_DONE;
                        if (!cand_c[NUM_STREAMS].any) begin
                            status_reg <= ST_NODATA;
                        end else begin
                            status_reg <= ST_GRANTED;
                            latch_reg  <= resched;
                            if (resched) begin
                                cur_reg   <= idx_c[NUM_STREAMS];
                                grant_reg <= 4'(idx_c[NUM_STREAMS]);
                            end else begin
                                grant_reg <= 4'(cur_reg);
                            end
                        end
                    end
                end
                S_MUL: begin
                    // report pass picks up the stream's own virtual time
                    if (!act_reg) op_base_reg <= vt_rd;
                    prod_reg  <= ie_reg ? (PW'(op_bytes_reg) * PW'(iw_rd)) : ONE_T;
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    state_reg <= S_DONE;
                    if (!act_reg) begin
                        sched_reg <= sum_sat;
                        lme_reg   <= rep_end_reg;
                        if (latch_reg && rep_next_reg != 16'd0 && ft_rd == '0) begin
                            op_base_reg  <= sum_sat;
                            op_bytes_reg <= act_bytes_rep;
                            act_reg      <= 1'b1;
                            state_reg    <= S_MUL;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        out_status_reg <= status_reg;
                        out_grant_reg  <= grant_reg;
                        out_time_reg   <= sched_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'd0, out_time_reg, out_grant_reg};

endmodule

@@ hw/rtl/wfss_check.sv @@
`timescale 1ns / 1ps
module wfss_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        pready
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped under stall");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("bad status code");

    a_nograntz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != 2'd0 |-> m_tdata[3:0] == 4'd0)
        else $error("stream index without grant");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind weighted_fair_stream_scheduler wfss_check u_wfss_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

@@ tb/weighted_fair_stream_scheduler_tb.sv @@
`timescale 1ns / 1ps
module weighted_fair_stream_scheduler_tb;
    import wfss_pkg::*;

    localparam int          N_STREAMS   = 16;
    localparam int          FRAC        = 16;
    localparam logic [47:0] TIME_SAT    = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] ONE_VT      = 64'd1 << FRAC;
    // undefined request modes, ignored by the block
    localparam logic [2:0]  MODE_RSVD_LO = 3'd5;
    localparam logic [2:0]  MODE_RSVD_HI = 3'd7;
    // register byte addresses
    localparam logic [2:0]  REG_INTERLEAVE = 3'd0;
    localparam logic [2:0]  REG_MAX_BYTES  = 3'd4;
    localparam int          SETTLE_CYCLES  = 40;
    localparam longint      CYCLE_LIMIT    = 2000000;
    localparam int          RAND_PER_PHASE = 383;

    typedef struct {
        logic [2:0]  mode;
        logic [3:0]  idx;
        logic [15:0] prio;
        logic        produced;
        logic [15:0] payload;
        logic        is_end;
        logic [15:0] next_bytes;
    } sched_req_t;

    typedef struct {
        logic [1:0]  status;
        logic [3:0]  grant;
        logic [47:0] gvt;
    } sched_rsp_t;

    // directed row: request plus an optional hand-written result
    typedef struct {
        sched_req_t req;
        logic       typed;
        sched_rsp_t rsp;
    } plan_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    weighted_fair_stream_scheduler DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // scheduler shadow state
    logic [16:0] inv_weight [N_STREAMS];
    logic [47:0] vtime      [N_STREAMS];
    logic [47:0] ftime      [N_STREAMS];
    logic [47:0] sched_vt;
    logic [3:0]  cur_stream;
    logic        msg_ended;
    logic        resched_held;
    logic        cfg_interleave;
    logic [15:0] cfg_cap;

    sched_rsp_t  rsp_pending [$];
    int          fails = 0;
    int          rsp_seen = 0;
    int          grants_seen = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    longint      cycles = 0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout, %0d results still pending", $realtime, rsp_pending.size());
            $display("weighted_fair_stream_scheduler_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [47:0] vt_sat_add(logic [47:0] a, logic [63:0] b);
        logic [63:0] s;
        s = {16'b0, a} + b;
        return (s > {16'b0, TIME_SAT}) ? TIME_SAT : s[47:0];
    endfunction

    function automatic logic [47:0] finish_of(int s, logic [15:0] nbytes);
        if (cfg_interleave)
            return vt_sat_add(vtime[s], 64'(nbytes) * 64'(inv_weight[s]));
        return vt_sat_add(vtime[s], ONE_VT);
    endfunction

    function automatic void arm_stream(int s, logic [15:0] nbytes);
        logic [15:0] cap;
        cap = (cfg_cap == 0) ? 16'd1 : cfg_cap;
        vtime[s] = sched_vt;
        ftime[s] = finish_of(s, (nbytes < cap) ? nbytes : cap);
    endfunction

    function automatic void shadow_reset();
        for (int i = 0; i < N_STREAMS; i++) begin
            inv_weight[i] = 17'(ONE_VT);
            vtime[i] = '0;
            ftime[i] = '0;
        end
        sched_vt = '0;
        cur_stream = '0;
        msg_ended = 1'b1;
        resched_held = 1'b0;
        cfg_interleave = 1'b0;
        cfg_cap = CAP_RESET;
    endfunction

    // advance the shadow by one request and return the result it gives
    function automatic sched_rsp_t schedule_step(sched_req_t r);
        sched_rsp_t o;
        logic       resched;
        logic       any;
        int         best;
        logic [16:0] p;
        o.status = ST_ACK;
        o.grant = '0;
        any = 1'b0;
        best = 0;
        case (r.mode)
            MODE_SET_PRIO: begin
                p = (r.prio == 0) ? 17'd1 : {1'b0, r.prio};
                inv_weight[r.idx] = 17'(ONE_VT / p);
            end
            MODE_ACTIVATE: begin
                if (ftime[r.idx] == 0 && r.next_bytes > 0)
                    arm_stream(r.idx, r.next_bytes);
            end
            MODE_PICK: begin
                resched = cfg_interleave | msg_ended;
                for (int i = 0; i < N_STREAMS; i++) begin
                    if (ftime[i] != 0 && (!any || ftime[i] < ftime[best])) begin
                        best = i;
                        any = 1'b1;
                    end
                end
                if (!any) begin
                    o.status = ST_NODATA;
                end else begin
                    resched_held = resched;
                    if (resched) begin
                        cur_stream = 4'(best);
                        ftime[best] = '0;
                    end
                    o.status = ST_GRANTED;
                    o.grant = cur_stream;
                end
            end
            MODE_REPORT: begin
                if (r.produced) begin
                    vtime[cur_stream] = finish_of(cur_stream, r.payload);
                    sched_vt = vtime[cur_stream];
                    msg_ended = r.is_end;
                    if (resched_held && r.next_bytes > 0) begin
                        if (ftime[cur_stream] == 0)
                            arm_stream(cur_stream, r.next_bytes);
                    end else if (!resched_held && r.next_bytes == 0) begin
                        ftime[cur_stream] = '0;
                    end
                end
            end
            MODE_DEACT: ftime[r.idx] = '0;
            default: ;
        endcase
        o.gvt = sched_vt;
        return o;
    endfunction

    // result side: random backpressure, compare against oldest expectation
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            sched_rsp_t e;
            rsp_seen++;
            if (rsp_pending.size() == 0) begin
                fails++;
                $display("%0t unexpected result: exp none got status %0d grant %0d vt %h",
                         $realtime, m_tuser, m_tdata[3:0], m_tdata[51:4]);
            end else begin
                e = rsp_pending.pop_front();
                if (e.status == ST_GRANTED)
                    grants_seen++;
                if (m_tuser !== e.status) begin
                    fails++;
                    $display("%0t status: exp %0d got %0d", $realtime, e.status, m_tuser);
                end
                if (m_tdata[3:0] !== e.grant) begin
                    fails++;
                    $display("%0t granted_stream: exp %0d got %0d",
                             $realtime, e.grant, m_tdata[3:0]);
                end
                if (m_tdata[51:4] !== e.gvt) begin
                    fails++;
                    $display("%0t virtual time: exp %h got %h", $realtime, e.gvt, m_tdata[51:4]);
                end
                if (m_tdata[55:52] !== 4'b0) begin
                    fails++;
                    $display("%0t pad bits: exp 0 got %h", $realtime, m_tdata[55:52]);
                end
            end
        end
    end

    // drive one request and hold it until the handshake; typed rows also
    // cross-check the predictor
    task automatic send_request(sched_req_t r, logic typed, sched_rsp_t want);
        sched_rsp_t got;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.mode;
        s_tlast <= r.is_end;
        s_tdata <= {3'b0, r.next_bytes, r.payload, r.produced, r.prio, r.idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        got = schedule_step(r);
        if (typed) begin
            if (got.status !== want.status || got.grant !== want.grant ||
                got.gvt !== want.gvt)
                $display("%0t note: typed row differs from predictor (exp %0d/%0d/%h)",
                         $realtime, want.status, want.grant, want.gvt);
            rsp_pending.push_back(want);
        end else begin
            rsp_pending.push_back(got);
        end
    endtask

    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (rsp_pending.size() != 0) @(posedge aclk);
        // let the block return to idle before registers change
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup then access; register takes it on the access edge
    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_INTERLEAVE)
            cfg_interleave = value[0];
        else
            cfg_cap = value[15:0];
    endtask

    task automatic set_regs(logic il, logic [15:0] cap);
        drain_pipe();
        reg_write(REG_INTERLEAVE, {31'b0, il});
        reg_write(REG_MAX_BYTES, {16'b0, cap});
    endtask

    function automatic sched_req_t rand_request();
        sched_req_t r;
        int pick;
        pick = $urandom_range(99);
        r.idx = 4'($urandom);
        r.prio = ($urandom_range(7) == 0) ? 16'($urandom_range(1, 3)) : 16'($urandom);
        r.produced = ($urandom_range(9) != 0);
        r.payload = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
        r.is_end = 1'($urandom);
        r.next_bytes = ($urandom_range(2) == 0) ? 16'd0 :
                       ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 1500));
        // mostly pick/report pairs over a pool of armed streams
        if (pick < 18)      r.mode = MODE_ACTIVATE;
        else if (pick < 52) r.mode = MODE_PICK;
        else if (pick < 86) r.mode = MODE_REPORT;
        else if (pick < 92) r.mode = MODE_SET_PRIO;
        else if (pick < 96) r.mode = MODE_DEACT;
        else                r.mode = 3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
        return r;
    endfunction

    function automatic plan_row_t row(logic [2:0] mode, logic [3:0] idx, logic [15:0] prio,
                                      logic prod, logic [15:0] pay, logic is_end,
                                      logic [15:0] nb);
        plan_row_t t;
        t.req = '{mode, idx, prio, prod, pay, is_end, nb};
        t.typed = 1'b0;
        t.rsp = '{ST_ACK, 4'd0, 48'd0};
        return t;
    endfunction

    function automatic plan_row_t typed_row(plan_row_t t, logic [1:0] st, logic [3:0] g,
                                            logic [47:0] vt);
        t.typed = 1'b1;
        t.rsp = '{st, g, vt};
        return t;
    endfunction

    plan_row_t plan [$];

    initial begin
        sched_rsp_t none;
        none = '{ST_ACK, 4'd0, 48'd0};
        shadow_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; fresh-from-reset and ignored rows carry typed results
        plan.push_back(typed_row(row(MODE_PICK, 0, 0, 0, 0, 0, 0), ST_NODATA, 0, 0));
        plan.push_back(typed_row(row(MODE_RSVD_LO, 15, 16'hFFFF, 1, 16'hFFFF, 1, 16'hFFFF),
                                 ST_ACK, 0, 0));
        plan.push_back(typed_row(row(MODE_RSVD_HI, 0, 0, 0, 0, 0, 0), ST_ACK, 0, 0));
        plan.push_back(typed_row(row(MODE_REPORT, 0, 0, 0, 100, 1, 5), ST_ACK, 0, 0));
        plan.push_back(typed_row(row(MODE_SET_PRIO, 15, 0, 0, 0, 0, 0), ST_ACK, 0, 0));
        plan.push_back(row(MODE_SET_PRIO, 3, 16'hFFFF, 0, 0, 0, 0));
        plan.push_back(row(MODE_ACTIVATE, 3, 0, 0, 0, 0, 16'hFFFF));
        plan.push_back(row(MODE_ACTIVATE, 3, 0, 0, 0, 0, 7));       // already active
        plan.push_back(row(MODE_ACTIVATE, 5, 0, 0, 0, 0, 0));       // no data
        plan.push_back(row(MODE_ACTIVATE, 0, 0, 0, 0, 0, 1));
        plan.push_back(row(MODE_ACTIVATE, 15, 0, 0, 0, 0, 300));
        plan.push_back(row(MODE_PICK, 0, 0, 0, 0, 0, 0));
        plan.push_back(row(MODE_REPORT, 0, 0, 0, 500, 0, 0));       // nothing produced
        plan.push_back(row(MODE_REPORT, 0, 0, 1, 16'hFFFF, 0, 0));  // message continues
        plan.push_back(row(MODE_PICK, 0, 0, 0, 0, 0, 0));           // same stream again
        plan.push_back(row(MODE_REPORT, 0, 0, 1, 0, 1, 5));
        plan.push_back(row(MODE_DEACT, 3, 0, 0, 0, 0, 0));
        plan.push_back(row(MODE_PICK, 0, 0, 0, 0, 0, 0));
        plan.push_back(row(MODE_REPORT, 0, 0, 1, 1200, 1, 16'hFFFF));
        plan.push_back(row(MODE_PICK, 0, 0, 0, 0, 0, 0));
        plan.push_back(row(MODE_REPORT, 0, 0, 1, 16'hFFFF, 1, 0));
        plan.push_back(row(MODE_DEACT, 15, 0, 0, 0, 0, 0));
        plan.push_back(row(MODE_DEACT, 0, 0, 0, 0, 0, 0));
        plan.push_back(row(MODE_PICK, 0, 0, 0, 0, 0, 0));
        foreach (plan[i])
            send_request(plan[i].req, plan[i].typed, plan[i].rsp);

        // random phases under several register settings, extremes included;
        // each set_regs first pauses the sender until all results are back
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_regs(1'b1, 16'd0);
                1: set_regs(1'b0, 16'hFFFF);
                2: set_regs(1'b1, 16'd1);
                default: set_regs(1'b1, 16'hFFFF);
            endcase
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                int n;
                n = ph * RAND_PER_PHASE + k;
                // sender busy / receiver slow, then swapped, then full rate
                if (n < 510) begin
                    send_idle_pct = 33;
                    recv_idle_pct = 74;
                end else if (n < 1020) begin
                    send_idle_pct = 74;
                    recv_idle_pct = 33;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                send_request(rand_request(), 1'b0, none);
            end
        end
        drain_pipe();

        $display("covered %0d requests, %0d results, %0d grants, four register settings",
                 plan.size() + 4 * RAND_PER_PHASE, rsp_seen, grants_seen);
        if (fails == 0) begin
            $display("weighted_fair_stream_scheduler_tb OK");
        end else begin
            $display("%0d mismatches", fails);
            $display("weighted_fair_stream_scheduler_tb NOT OK");
        end
        $finish;
    end

endmodule
